[hdl/sprite_frame_sequencer_assert.svh]
// ----------------------------------------------------------------------------
// sprite frame sequencer assertion macros
// shared property wrappers clocked on clk_i and disabled during reset
// ----------------------------------------------------------------------------
`ifndef SPRITE_FRAME_SEQUENCER_ASSERT_SVH
`define SPRITE_FRAME_SEQUENCER_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define SFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// property whose consequent is checked in the cycle after the antecedent
`define SFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/sfs_pkg.sv]
// ----------------------------------------------------------------------------
// sfs_pkg
// codes, widths and shared types of the sprite frame sequencer
// ----------------------------------------------------------------------------
package sfs_pkg;

  localparam int MODE_W      = 3;
  localparam int ELAPSED_W   = 16;
  localparam int COUNT_W     = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int TEX_U_W     = 8;
  localparam int TEX_V_W     = 17;
  localparam int FRAME_OUT_W = 8;
  localparam int ACC_W       = 17;
  localparam int TILE_W      = 9;

  // input mode codes
  localparam logic [MODE_W-1:0] MODE_TICK      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ONCE      = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ONCE_STOP = 3'd2;
  localparam logic [MODE_W-1:0] MODE_LOOP      = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CYCLE     = 3'd4;
  localparam logic [MODE_W-1:0] MODE_STOP      = 3'd5;
  localparam logic [MODE_W-1:0] MODE_RESET     = 3'd6;
  // active mode when no animation runs
  localparam logic [MODE_W-1:0] MODE_STATIC    = 3'd0;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_FRAMES = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_FRAME   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_DELAY  = 3'd4;

  localparam logic [ACC_W-1:0] ACC_MAX = 17'h1FFFF;

  typedef struct packed {
    logic                   emit;
    logic                   running;
    logic [FRAME_OUT_W-1:0] frame_now;
  } sfs_status_t;

  typedef struct packed {
    logic [TILE_W-1:0] tile_width;
    logic [TILE_W-1:0] tile_height;
  } sfs_geom_t;

endpackage

[hdl/sfs_if.sv]
// ----------------------------------------------------------------------------
// sfs channel interfaces
// item, result and configuration channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface sfs_item_if;
  logic                                 valid;
  logic                                 ready;
  logic [sfs_pkg::MODE_W-1:0]           mode;
  logic [sfs_pkg::ELAPSED_W-1:0]        elapsed;
  logic signed [sfs_pkg::COUNT_W-1:0]   loop_count;

  modport source (output valid, mode, elapsed, loop_count, input ready);
  modport sink   (input valid, mode, elapsed, loop_count, output ready);
endinterface

interface sfs_result_if;
  logic                               valid;
  logic                               ready;
  logic                               uv_written;
  logic [sfs_pkg::TEX_U_W-1:0]        tex_u;
  logic [sfs_pkg::TEX_V_W-1:0]        tex_v;
  logic [sfs_pkg::FRAME_OUT_W-1:0]    frame_now;
  logic                               running;

  modport source (output valid, uv_written, tex_u, tex_v, frame_now, running, input ready);
  modport sink   (input valid, uv_written, tex_u, tex_v, frame_now, running, output ready);
endinterface

interface sfs_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [sfs_pkg::CFG_IDX_W-1:0]     index;
  logic [sfs_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hdl/sfs_ctrl.sv]
// ----------------------------------------------------------------------------
// sfs_ctrl
// configuration registers and animation state update for one item
// ----------------------------------------------------------------------------
module sfs_ctrl #(
  parameter int FRAME_BITS = 8,
  parameter int IDX_W      = 9
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [sfs_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [sfs_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                accept_i,
  input  logic [sfs_pkg::MODE_W-1:0]          mode_i,
  input  logic [sfs_pkg::ELAPSED_W-1:0]       elapsed_i,
  input  logic signed [sfs_pkg::COUNT_W-1:0]  loop_count_i,
  output sfs_pkg::sfs_status_t                status_o,
  output logic [IDX_W-1:0]                    emit_idx_o,
  output sfs_pkg::sfs_geom_t                  geom_o
);
  import sfs_pkg::*;

  localparam int LT_W = (FRAME_BITS + 1 > TILE_W) ? FRAME_BITS + 1 : TILE_W;
  localparam logic [LT_W-1:0] FRAMES_MAX = LT_W'(1 << FRAME_BITS);

  logic [8:0]              total_q;
  logic [7:0]              base_q;
  logic [TILE_W-1:0]       tw_q, th_q;
  logic [15:0]             delay_q;

  logic [MODE_W-1:0]       active_q, active_d;
  logic [FRAME_BITS-1:0]   fi_q, fi_d;
  logic                    back_q, back_d;
  logic signed [COUNT_W-1:0] loops_q, loops_d;
  logic [ACC_W-1:0]        acc_q, acc_d;

  logic [LT_W-1:0]         tf;
  logic [FRAME_BITS-1:0]   last;
  logic [ACC_W:0]          acc_sum;
  logic [ACC_W-1:0]        acc_sat;
  logic                    emit, emit_new;
  logic [FRAME_BITS-1:0]   fi_inc, fi_dec;
  logic signed [COUNT_W-1:0] loops_dec;
  logic                    loops_pos;
  logic [IDX_W-1:0]        fi_ext;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= 9'd1;
      base_q  <= 8'd0;
      tw_q    <= 9'd16;
      th_q    <= 9'd16;
      delay_q <= 16'd0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_TOTAL_FRAMES: total_q <= cfg_data_i[8:0];
        REG_BASE_FRAME:   base_q  <= cfg_data_i[7:0];
        REG_TILE_WIDTH:   tw_q    <= cfg_data_i[8:0];
        REG_TILE_HEIGHT:  th_q    <= cfg_data_i[8:0];
        REG_FRAME_DELAY:  delay_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // last frame index, zero frames acts as one, clamp to frame range
  always_comb begin
    tf = LT_W'(total_q);
    if (tf == '0) begin
      tf = LT_W'(1);
    end else if (tf > FRAMES_MAX) begin
      tf = FRAMES_MAX;
    end
    last = FRAME_BITS'(tf - LT_W'(1));
  end

  assign acc_sum   = {1'b0, acc_q} + (ACC_W + 1)'(elapsed_i);
  assign acc_sat   = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
  assign fi_inc    = fi_q + FRAME_BITS'(1);
  assign fi_dec    = fi_q - FRAME_BITS'(1);
  assign loops_dec = loops_q - COUNT_W'(1);
  assign loops_pos = !loops_q[COUNT_W-1] && (loops_q != '0);

  always_comb begin
    logic [FRAME_BITS-1:0] step;
    active_d = active_q;
    fi_d     = fi_q;
    back_d   = back_q;
    loops_d  = loops_q;
    acc_d    = acc_q;
    emit     = 1'b0;
    emit_new = 1'b0;
    step     = back_q ? fi_dec : fi_inc;
    case (mode_i)
      MODE_TICK: begin
        if (active_q != MODE_STATIC) begin
          acc_d = acc_sat;
          if (acc_sat > ACC_W'(delay_q)) begin
            acc_d = '0;
            case (active_q)
              MODE_ONCE: begin
                emit     = 1'b1;
                emit_new = 1'b1;
                if (fi_q < last) begin
                  fi_d = fi_inc;
                end else begin
                  fi_d     = '0;
                  active_d = MODE_STATIC;
                end
              end
              MODE_ONCE_STOP: begin
                emit     = 1'b1;
                emit_new = 1'b1;
                if (fi_q < last) begin
                  fi_d = fi_inc;
                end else begin
                  active_d = MODE_STATIC;
                end
              end
              MODE_LOOP: begin
                emit = 1'b1;
                if (fi_q < last) begin
                  fi_d = fi_inc;
                end else begin
                  fi_d = '0;
                  // zero or negative count loops forever
                  if (loops_pos) begin
                    loops_d = loops_dec;
                    if (loops_dec == '0) active_d = MODE_STATIC;
                  end
                end
              end
              MODE_CYCLE: begin
                emit = 1'b1;
                if (last == '0) begin
                  fi_d = '0;
                end else begin
                  fi_d = step;
                  if (step == '0 || step == last) back_d = !back_q;
                end
              end
              default: ;
            endcase
          end
        end
      end
      MODE_ONCE, MODE_ONCE_STOP, MODE_CYCLE: begin
        active_d = mode_i;
      end
      MODE_LOOP: begin
        active_d = MODE_LOOP;
        loops_d  = loop_count_i;
      end
      MODE_STOP: begin
        active_d = MODE_STATIC;
      end
      MODE_RESET: begin
        active_d = MODE_STATIC;
        fi_d     = '0;
        emit     = 1'b1;
        emit_new = 1'b1;
        // saturated so the next started mode advances on its first tick
        acc_d    = ACC_MAX;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= MODE_STATIC;
      fi_q     <= '0;
      back_q   <= 1'b0;
      loops_q  <= '0;
      acc_q    <= '0;
    end else if (accept_i) begin
      active_q <= active_d;
      fi_q     <= fi_d;
      back_q   <= back_d;
      loops_q  <= loops_d;
      acc_q    <= acc_d;
    end
  end

  assign fi_ext             = IDX_W'(fi_d);
  assign status_o.emit      = emit;
  assign status_o.running   = (active_d != MODE_STATIC);
  assign status_o.frame_now = fi_ext[FRAME_OUT_W-1:0];
  assign emit_idx_o         = IDX_W'(emit_new ? fi_d : fi_q) + IDX_W'(base_q);
  assign geom_o.tile_width  = tw_q;
  assign geom_o.tile_height = th_q;

endmodule

[hdl/sfs_uv_unit.sv]
// ----------------------------------------------------------------------------
// sfs_uv_unit
// atlas coordinate unit: one shared multiplier stepped by a small sequencer
// ----------------------------------------------------------------------------
module sfs_uv_unit #(
  parameter int ATLAS_WIDTH = 256,
  parameter int IDX_W       = 9
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic                            emit_i,
  input  logic [IDX_W-1:0]                idx_i,
  input  sfs_pkg::sfs_geom_t              geom_i,
  input  logic                            take_i,
  output logic                            idle_o,
  output logic                            done_o,
  output logic [sfs_pkg::TEX_U_W-1:0]     tex_u_o,
  output logic [sfs_pkg::TEX_V_W-1:0]     tex_v_o
);
  import sfs_pkg::*;

  localparam int PROD_W = IDX_W + TILE_W;
  // floor reciprocal: the estimated quotient is low by at most one
  localparam int RECIP  = (1 << PROD_W) / ATLAS_WIDTH;
  localparam logic [PROD_W-1:0] RECIP_C = PROD_W'(RECIP);
  localparam logic [PROD_W-1:0] ATLAS_C = PROD_W'(ATLAS_WIDTH);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PROD  = 3'd1;
  localparam logic [2:0] ST_RECIP = 3'd2;
  localparam logic [2:0] ST_BACK  = 3'd3;
  localparam logic [2:0] ST_FIX   = 3'd4;
  localparam logic [2:0] ST_V     = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]          state_q, state_d;
  logic [PROD_W-1:0]   p_q, q_q, r_q;
  logic [TEX_V_W-1:0]  v_q;
  logic [PROD_W-1:0]   mul_a, mul_b;
  logic [2*PROD_W-1:0] mul_p;

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_PROD: begin
        mul_a = p_q;
        mul_b = PROD_W'(geom_i.tile_width);
      end
      ST_RECIP: begin
        mul_a = p_q;
        mul_b = RECIP_C;
      end
      ST_BACK: begin
        mul_a = q_q;
        mul_b = ATLAS_C;
      end
      ST_V: begin
        mul_a = q_q;
        mul_b = PROD_W'(geom_i.tile_height);
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (start_i) state_d = emit_i ? ST_PROD : ST_DONE;
      ST_PROD:  state_d = ST_RECIP;
      ST_RECIP: state_d = ST_BACK;
      ST_BACK:  state_d = ST_FIX;
      ST_FIX:   state_d = ST_V;
      ST_V:     state_d = ST_DONE;
      ST_DONE:  if (take_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE:  if (start_i) p_q <= PROD_W'(idx_i);
      ST_PROD:  p_q <= mul_p[PROD_W-1:0];
      ST_RECIP: q_q <= mul_p[2*PROD_W-1:PROD_W];
      ST_BACK:  r_q <= p_q - mul_p[PROD_W-1:0];
      ST_FIX: begin
        if (r_q >= ATLAS_C) begin
          r_q <= r_q - ATLAS_C;
          q_q <= q_q + PROD_W'(1);
        end
      end
      ST_V:     v_q <= mul_p[TEX_V_W-1:0];
      default: ;
    endcase
  end

  assign idle_o  = (state_q == ST_IDLE);
  assign done_o  = (state_q == ST_DONE);
  assign tex_u_o = r_q[TEX_U_W-1:0];
  assign tex_v_o = v_q;

endmodule

[hdl/sprite_frame_sequencer.sv]
// ----------------------------------------------------------------------------
// sprite_frame_sequencer
// sprite animation frame sequencer with atlas coordinate output
// ----------------------------------------------------------------------------
// Each item is a tick or a command and gives exactly one result beat. The
// animation state is updated in the cycle the item is taken; atlas coordinates
// are then worked out on one shared multiplier in four passes (index times tile
// width, reciprocal quotient estimate, back-multiply for the remainder, quotient
// times tile height) plus one correction step. An item that writes coordinates
// steps through the product, reciprocal, back-multiply, correction and tile
// height states before its result is loaded; an item without coordinates goes
// straight to the done state. The input is not ready while the unit works, and a
// result that waits in the output register holds the unit until it is taken.
// Configuration writes are always taken.
module sprite_frame_sequencer #(
  parameter int ATLAS_WIDTH = 256,
  parameter int FRAME_BITS  = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  sfs_cfg_if.sink             cfg_i,
  sfs_item_if.sink            item_i,
  sfs_result_if.source        result_o
);
  import sfs_pkg::*;

  localparam int IDX_W = ((FRAME_BITS > 8) ? FRAME_BITS : 8) + 1;

  logic               accept;
  logic               uv_idle, uv_done, load;
  sfs_status_t        status, pend_q;
  sfs_geom_t          geom;
  logic [IDX_W-1:0]   emit_idx;
  logic [TEX_U_W-1:0] uv_u;
  logic [TEX_V_W-1:0] uv_v;

  logic               out_valid_q;
  logic               out_uvw_q, out_run_q;
  logic [TEX_U_W-1:0] out_u_q;
  logic [TEX_V_W-1:0] out_v_q;
  logic [FRAME_OUT_W-1:0] out_frame_q;

  assign cfg_i.ready  = 1'b1;
  assign item_i.ready = uv_idle;
  assign accept       = item_i.valid && uv_idle;

  sfs_ctrl #(
    .FRAME_BITS (FRAME_BITS),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_i.valid),
    .cfg_index_i  (cfg_i.index),
    .cfg_data_i   (cfg_i.data),
    .accept_i     (accept),
    .mode_i       (item_i.mode),
    .elapsed_i    (item_i.elapsed),
    .loop_count_i (item_i.loop_count),
    .status_o     (status),
    .emit_idx_o   (emit_idx),
    .geom_o       (geom)
  );

  sfs_uv_unit #(
    .ATLAS_WIDTH (ATLAS_WIDTH),
    .IDX_W       (IDX_W)
  ) u_uv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .emit_i  (status.emit),
    .idx_i   (emit_idx),
    .geom_i  (geom),
    .take_i  (load),
    .idle_o  (uv_idle),
    .done_o  (uv_done),
    .tex_u_o (uv_u),
    .tex_v_o (uv_v)
  );

  // status of the item in flight
  always_ff @(posedge clk_i) begin
    if (accept) pend_q <= status;
  end

  assign load = uv_done && (!out_valid_q || result_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_uvw_q   <= pend_q.emit;
      out_u_q     <= pend_q.emit ? uv_u : '0;
      out_v_q     <= pend_q.emit ? uv_v : '0;
      out_frame_q <= pend_q.frame_now;
      out_run_q   <= pend_q.running;
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.uv_written = out_uvw_q;
  assign result_o.tex_u      = out_u_q;
  assign result_o.tex_v      = out_v_q;
  assign result_o.frame_now  = out_frame_q;
  assign result_o.running    = out_run_q;

endmodule

[hdl/sfs_checker.sv]
// ----------------------------------------------------------------------------
// sfs_checker
// port level checks of the sprite frame sequencer, bound to the top level
// ----------------------------------------------------------------------------
`include "sprite_frame_sequencer_assert.svh"

module sfs_checker (
  input logic          clk_i,
  input logic          rst_ni,
  sfs_cfg_if.sink      cfg,
  sfs_item_if.sink     item,
  sfs_result_if.source result
);

  // a taken item occupies the unit, so ready drops after the item beat
  `SFS_ASSERT_NEXT(a_busy_after_item, item.valid && item.ready, !item.ready, "ready after item beat")

  // result beat without coordinates carries zero coordinates
  `SFS_ASSERT(a_zero_uv, !(result.valid && !result.uv_written) || (result.tex_u == 8'd0 && result.tex_v == 17'd0), "coordinates without uv_written")

  // a stalled result beat stays put
  `SFS_ASSERT_NEXT(a_result_hold, result.valid && !result.ready, result.valid && $stable(result.tex_v) && $stable(result.frame_now), "stalled result changed")

  // configuration writes are never back-pressured
  `SFS_ASSERT(a_cfg_ready, cfg.ready, "configuration not ready")

endmodule

bind sprite_frame_sequencer sfs_checker u_sfs_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .cfg    (cfg_i),
  .item   (item_i),
  .result (result_o)
);
